### hdl/almm_pkg.sv
// almm_pkg: shared widths, command codes and request structs for the affine layer block
// depends on: nothing
`timescale 1ns / 1ps
`default_nettype none

package almm_pkg;

  // field widths
  localparam int VAL_W  = 16;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int DIM_W  = 7;
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 2;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 40;

  // most results one compute request may produce
  localparam int RESULT_CAP = 64;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_WEIGHT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_INPUT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_BIAS   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COMPUTE     = 2'd3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_ROWS_USED  = 2'd0;
  localparam logic [IDX_W-1:0] REG_INNER_USED = 2'd1;
  localparam logic [IDX_W-1:0] REG_COLS_USED  = 2'd2;

  // one store write
  typedef struct packed {
    logic                    wr_weight;
    logic                    wr_input;
    logic                    wr_bias;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } almm_load_t;

  // one multiply-accumulate step issued by the sequencer
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last_col;
    logic [DIM_W-1:0] k;
    logic [COL_W-1:0] col;
  } almm_issue_t;

endpackage

`default_nettype wire

### hdl/almm_datapath.sv
// almm_datapath: weight, input and bias memories plus the read / multiply / accumulate /
// saturate pipeline; depends on almm_pkg
`timescale 1ns / 1ps
`default_nettype none

module almm_datapath #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 64
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire almm_pkg::almm_load_t           load,
  input  wire almm_pkg::almm_issue_t          issue,
  input  wire [almm_pkg::ROW_W-1:0]           row,
  output logic                                res_valid,
  output logic [almm_pkg::COL_W-1:0]          res_col,
  output logic signed [almm_pkg::VAL_W-1:0]   res_value,
  output logic                                res_sat,
  output logic                                res_last
);
  import almm_pkg::*;

  localparam int W_DEPTH = MAX_ROWS * MAX_INNER;
  localparam int X_DEPTH = MAX_INNER * MAX_COLS;
  localparam int W_AW    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int X_AW    = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
  localparam int B_AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic signed [VAL_W-1:0] weight_mem [0:W_DEPTH-1];
  logic signed [VAL_W-1:0] input_mem  [0:X_DEPTH-1];
  logic signed [VAL_W-1:0] bias_mem   [0:MAX_ROWS-1];

  logic [W_AW-1:0] w_waddr, w_raddr;
  logic [X_AW-1:0] x_waddr, x_raddr;
  logic [B_AW-1:0] b_waddr, b_raddr;
  logic            w_we, x_we, b_we;

  // stage 1: read data
  logic signed [VAL_W-1:0] w_rd, x_rd, bias_rd;
  logic s1_valid, s1_first, s1_last_k, s1_last_col;
  logic [COL_W-1:0] s1_col;
  // stage 2: product
  logic signed [PROD_W-1:0] prod;
  logic s2_valid, s2_first, s2_last_k, s2_last_col;
  logic [COL_W-1:0] s2_col;
  // stage 3: accumulator
  logic signed [ACC_W-1:0] acc, acc_next, bias_ext;
  logic s3_done, s3_last_col;
  logic [COL_W-1:0] s3_col;
  // saturation
  logic sat_pos, sat_neg;

  // store addresses, row-major as row * width + column
  always_comb begin
    w_waddr = W_AW'(32'(load.row) * MAX_INNER + 32'(load.col));
    x_waddr = X_AW'(32'(load.row) * MAX_COLS + 32'(load.col));
    b_waddr = B_AW'(load.row);
    w_raddr = W_AW'(32'(row) * MAX_INNER + 32'(issue.k));
    x_raddr = X_AW'(32'(issue.k) * MAX_COLS + 32'(issue.col));
    b_raddr = B_AW'(row);
    w_we = load.wr_weight && (32'(load.row) < MAX_ROWS) && (32'(load.col) < MAX_INNER);
    x_we = load.wr_input && (32'(load.row) < MAX_INNER) && (32'(load.col) < MAX_COLS);
    b_we = load.wr_bias && (32'(load.row) < MAX_ROWS);
  end

  // memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[w_waddr] <= load.value;
    end
    if (x_we) begin
      input_mem[x_waddr] <= load.value;
    end
    if (b_we) begin
      bias_mem[b_waddr] <= load.value;
    end
    if (issue.valid) begin
      w_rd    <= weight_mem[w_raddr];
      x_rd    <= input_mem[x_raddr];
      bias_rd <= bias_mem[b_raddr];
    end
  end

  // pipeline control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_done   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1_valid  <= issue.valid;
      s2_valid  <= s1_valid;
      s3_done   <= s2_valid && s2_last_k;
      res_valid <= s3_done;
    end
  end

  // bias moved to Q16.16 for the first term of a column
  assign bias_ext = ACC_W'(bias_rd) <<< 8;

  always_comb begin
    acc_next = (s2_first ? bias_ext : acc) + ACC_W'(prod);
  end

  // payload stages
  always_ff @(posedge clk) begin
    s1_first    <= issue.first;
    s1_last_k   <= issue.last_k;
    s1_last_col <= issue.last_col;
    s1_col      <= issue.col;

    prod        <= w_rd * x_rd;
    s2_first    <= s1_first;
    s2_last_k   <= s1_last_k;
    s2_last_col <= s1_last_col;
    s2_col      <= s1_col;

    if (s2_valid) begin
      acc <= acc_next;
    end
    s3_last_col <= s2_last_col;
    s3_col      <= s2_col;
  end

  // floor shift by 8, then clip to 16 bits
  assign sat_pos = !acc[ACC_W-1] && (|acc[ACC_W-2:VAL_W+7]);
  assign sat_neg = acc[ACC_W-1] && !(&acc[ACC_W-2:VAL_W+7]);

  always_ff @(posedge clk) begin
    res_col  <= s3_col;
    res_last <= s3_last_col;
    res_sat  <= sat_pos || sat_neg;
    if (sat_pos) begin
      res_value <= {1'b0, {(VAL_W-1){1'b1}}};
    end else if (sat_neg) begin
      res_value <= {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      res_value <= acc[VAL_W+7:8];
    end
  end

endmodule

`default_nettype wire

### hdl/affine_layer_matrix_multiply_top.sv
// affine_layer_matrix_multiply_top: Y = W*X + B in Q8.8, config registers and row sequencer
// depends on almm_pkg and almm_datapath
//
//   channel   signals                                       handshake
//   request   command, row_index, col_index, element_value  start & !busy
//   result    out_row, out_col, out_value, saturated, last  out_valid, one cycle
//   config    cfg_index, cfg_data                           cfg_we, one cycle
//
// loads leave busy low.
// a compute request covers ncols * inner_used multiply-accumulates, ncols = min(cols_used, 64):
// one multiply-accumulate per cycle, bounded by the single read port of each store.
// results come one per column; the receiver cannot stall them.
// a compute whose row is not below rows_used gives nothing.
// synchronous reset sets all three dimension registers to 64, clamped to the store sizes; stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module affine_layer_matrix_multiply_top #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 64
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // requests
  input  wire                                 start,
  output logic                                busy,
  input  wire [almm_pkg::CMD_W-1:0]           command,
  input  wire [almm_pkg::ROW_W-1:0]           row_index,
  input  wire [almm_pkg::COL_W-1:0]           col_index,
  input  wire signed [almm_pkg::VAL_W-1:0]    element_value,
  // results
  output logic                                out_valid,
  output logic [almm_pkg::ROW_W-1:0]          out_row,
  output logic [almm_pkg::COL_W-1:0]          out_col,
  output logic signed [almm_pkg::VAL_W-1:0]   out_value,
  output logic                                saturated,
  output logic                                last,
  // configuration
  input  wire                                 cfg_we,
  input  wire [almm_pkg::IDX_W-1:0]           cfg_index,
  input  wire [almm_pkg::DIM_W-1:0]           cfg_data
);
  import almm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state, state_next;
  logic [DIM_W-1:0] rows_used, inner_used, cols_used;
  logic [DIM_W-1:0] ncols;
  logic [DIM_W-1:0] k, k_next;
  logic [COL_W-1:0] col, col_next;
  logic [ROW_W-1:0] row, row_next;
  logic             accept;
  logic             last_k, last_col;
  almm_load_t       load;
  almm_issue_t      issue;

  // zero reads as one, anything above the store size as the store size
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int top);
    logic [DIM_W-1:0] m;
    m = (v == '0) ? DIM_W'(1) : v;
    if (32'(m) > top) begin
      m = DIM_W'(top);
    end
    return m;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used  <= clamp_dim(DIM_W'(64), MAX_ROWS);
      inner_used <= clamp_dim(DIM_W'(64), MAX_INNER);
      cols_used  <= clamp_dim(DIM_W'(64), MAX_COLS);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_USED:  rows_used  <= clamp_dim(cfg_data, MAX_ROWS);
        REG_INNER_USED: inner_used <= clamp_dim(cfg_data, MAX_INNER);
        REG_COLS_USED:  cols_used  <= clamp_dim(cfg_data, MAX_COLS);
        default: ;
      endcase
    end
  end

  assign ncols    = (32'(cols_used) > RESULT_CAP) ? DIM_W'(RESULT_CAP) : cols_used;
  assign accept   = start && !busy;
  assign busy     = (state != ST_IDLE);
  assign last_k   = (k == inner_used - DIM_W'(1));
  assign last_col = ({1'b0, col} == ncols - DIM_W'(1));

  // store writes go straight out on the accepting edge
  always_comb begin
    load.wr_weight = accept && (command == CMD_LOAD_WEIGHT);
    load.wr_input  = accept && (command == CMD_LOAD_INPUT);
    load.wr_bias   = accept && (command == CMD_LOAD_BIAS);
    load.row       = row_index;
    load.col       = col_index;
    load.value     = element_value;
  end

  // one multiply-accumulate per cycle, column by column
  always_comb begin
    issue.valid    = (state == ST_ISSUE);
    issue.first    = (k == '0);
    issue.last_k   = last_k;
    issue.last_col = last_col;
    issue.k        = k;
    issue.col      = col;
  end

  // sequencer
  always_comb begin
    state_next = state;
    k_next     = k;
    col_next   = col;
    row_next   = row;
    case (state)
      ST_IDLE: begin
        if (accept && (command == CMD_COMPUTE) && ({1'b0, row_index} < rows_used)) begin
          state_next = ST_ISSUE;
          row_next   = row_index;
          k_next     = '0;
          col_next   = '0;
        end
      end
      ST_ISSUE: begin
        if (last_k) begin
          k_next = '0;
          if (last_col) begin
            state_next = ST_DRAIN;
          end else begin
            col_next = col + COL_W'(1);
          end
        end else begin
          k_next = k + DIM_W'(1);
        end
      end
      ST_DRAIN: begin
        if (out_valid && last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    k   <= k_next;
    col <= col_next;
    row <= row_next;
  end

  // row stays put until the block goes idle after the last result
  assign out_row = row;

  almm_datapath #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .issue     (issue),
    .row       (row),
    .res_valid (out_valid),
    .res_col   (out_col),
    .res_value (out_value),
    .res_sat   (saturated),
    .res_last  (last)
  );

endmodule

`default_nettype wire

### hdl/almm_checker.sv
// almm_checker: port-level assertions for the affine layer block, bound to the top level
// depends on almm_pkg and affine_layer_matrix_multiply_top
`timescale 1ns / 1ps
`default_nettype none

module almm_checker (
  input wire                                 clk,
  input wire                                 rst,
  input wire                                 busy,
  input wire                                 out_valid,
  input wire [almm_pkg::ROW_W-1:0]           out_row,
  input wire signed [almm_pkg::VAL_W-1:0]    out_value,
  input wire                                 saturated,
  input wire                                 last
);
  import almm_pkg::*;

  // results only while a compute request is in progress
  a_result_in_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> busy)
    else $error("result shown while idle");

  // the last result of a row frees the block on the next cycle
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |=> !busy)
    else $error("still busy after last result");

  // the output row does not move during a compute request
  a_row_stable: assert property (@(posedge clk) disable iff (rst)
    busy && $past(busy) |-> $stable(out_row))
    else $error("output row changed mid request");

  // a clipped result sits at one of the two rails
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (out_value == 16'sh7fff) || (out_value == 16'sh8000))
    else $error("saturated result off the rails");

  // reset leaves the block idle
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !out_valid)
    else $error("not idle after reset");

endmodule

bind affine_layer_matrix_multiply_top almm_checker u_almm_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .out_valid (out_valid),
  .out_row   (out_row),
  .out_value (out_value),
  .saturated (saturated),
  .last      (last)
);

`default_nettype wire

### sim/affine_layer_matrix_multiply_top_tb.sv
// affine_layer_matrix_multiply_top_tb: self-checking bench for the Q8.8 affine layer block
// loads weight, input and bias elements, requests output rows and checks every element
// depends on almm_pkg and affine_layer_matrix_multiply_top
`timescale 1ns / 1ps

module affine_layer_matrix_multiply_top_tb;
  import almm_pkg::*;

  localparam int STORE_DIM     = 64;
  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 10;

  // one predicted output element
  typedef struct {
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    sat;
    logic                    last;
  } layer_element_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [CMD_W-1:0]        command = CMD_LOAD_WEIGHT;
  logic [ROW_W-1:0]        row_index = '0;
  logic [COL_W-1:0]        col_index = '0;
  logic signed [VAL_W-1:0] element_value = '0;
  logic                    out_valid;
  logic [ROW_W-1:0]        out_row;
  logic [COL_W-1:0]        out_col;
  logic signed [VAL_W-1:0] out_value;
  logic                    saturated;
  logic                    last;
  logic                    cfg_we = 1'b0;
  logic [IDX_W-1:0]        cfg_index = REG_ROWS_USED;
  logic [DIM_W-1:0]        cfg_data = '0;

  // predictor copy of the stores and dimensions
  logic signed [VAL_W-1:0] weight_mem [STORE_DIM * STORE_DIM];
  logic signed [VAL_W-1:0] input_mem [STORE_DIM * STORE_DIM];
  logic signed [VAL_W-1:0] bias_mem [STORE_DIM];
  bit                      weight_known [STORE_DIM * STORE_DIM];
  bit                      input_known [STORE_DIM * STORE_DIM];
  bit                      bias_known [STORE_DIM];
  int                      rows_act = STORE_DIM;
  int                      inner_act = STORE_DIM;
  int                      cols_act = STORE_DIM;

  layer_element_t          expected_elements [$];
  int                      errors = 0;
  int                      requests_done = 0;
  int                      calm_after = 32'h7FFF_FFFF;
  bit                      gaps_on = 1'b1;
  int                      quiet_cycles = 0;

  affine_layer_matrix_multiply_top #(
    .MAX_ROWS (STORE_DIM),
    .MAX_INNER(STORE_DIM),
    .MAX_COLS (STORE_DIM)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .row_index    (row_index),
    .col_index    (col_index),
    .element_value(element_value),
    .out_valid    (out_valid),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_value    (out_value),
    .saturated    (saturated),
    .last         (last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) $display("mismatch @%0t: %s", $time, what);
  endtask

  // register value to dimension: zero acts as one, above the store size acts as the size
  function automatic int effective_dim(input logic [DIM_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > STORE_DIM) return STORE_DIM;
    return int'(raw);
  endfunction

  function automatic int active_cols();
    return (cols_act > RESULT_CAP) ? RESULT_CAP : cols_act;
  endfunction

  // apply one accepted request to the predictor, queue the row elements it yields
  task automatic predict_request(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                                 input logic [COL_W-1:0] col,
                                 input logic signed [VAL_W-1:0] val);
    int             ncols;
    longint         acc;
    longint         q;
    layer_element_t e;
    case (cmd)
      CMD_LOAD_WEIGHT: begin
        weight_mem[row * STORE_DIM + col] = val;
        weight_known[row * STORE_DIM + col] = 1'b1;
      end
      CMD_LOAD_INPUT: begin
        input_mem[row * STORE_DIM + col] = val;
        input_known[row * STORE_DIM + col] = 1'b1;
      end
      CMD_LOAD_BIAS: begin
        bias_mem[row] = val;
        bias_known[row] = 1'b1;
      end
      default: begin
        if (row < rows_act) begin
          ncols = active_cols();
          for (int c = 0; c < ncols; c++) begin
            // bias at Q16.16 plus the exact dot product
            acc = bias_mem[row];
            acc = acc <<< 8;
            for (int k = 0; k < inner_act; k++)
              acc = acc + weight_mem[row * STORE_DIM + k] * input_mem[k * STORE_DIM + c];
            // floor back to Q8.8, then clip
            q = acc >>> 8;
            e.sat = 1'b0;
            if (q > 32767) begin
              q = 32767;
              e.sat = 1'b1;
            end else if (q < -32768) begin
              q = -32768;
              e.sat = 1'b1;
            end
            e.row = row;
            e.col = COL_W'(c);
            e.value = q[VAL_W-1:0];
            e.last = (c == ncols - 1);
            expected_elements.push_back(e);
          end
        end
      end
    endcase
  endtask

  // drive one request and hold it until accepted; start stays high on return
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                              input logic [COL_W-1:0] col,
                              input logic signed [VAL_W-1:0] val);
    int gap;
    gap = 0;
    if (gaps_on && requests_done < calm_after && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    row_index <= row;
    col_index <= col;
    element_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(cmd, row, col, val);
    requests_done++;
  endtask

  // drain all results and let the block finish any silent work
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_elements.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three dimension registers while idle
  task automatic set_dims(input logic [DIM_W-1:0] rows_raw, inner_raw, cols_raw);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_ROWS_USED;
    cfg_data <= rows_raw;
    @(posedge clk);
    cfg_index <= REG_INNER_USED;
    cfg_data <= inner_raw;
    @(posedge clk);
    cfg_index <= REG_COLS_USED;
    cfg_data <= cols_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    rows_act = effective_dim(rows_raw);
    inner_act = effective_dim(inner_raw);
    cols_act = effective_dim(cols_raw);
  endtask

  // mostly mixed magnitudes, with the Q8.8 extremes showing up often
  function automatic logic signed [VAL_W-1:0] pick_value();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = int'($urandom_range(0, 1023)) - 512;
      2: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0000_7FFF;
          1: v = 32'hFFFF_8000;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      default: v = int'($urandom_range(0, 8191)) - 4096;
    endcase
    return v[VAL_W-1:0];
  endfunction

  // a row may be computed only once every element it reads has been loaded
  function automatic bit row_ready(input int r);
    if (r >= rows_act) return 1'b1;
    if (!bias_known[r]) return 1'b0;
    for (int k = 0; k < inner_act; k++) begin
      if (!weight_known[r * STORE_DIM + k]) return 1'b0;
      for (int c = 0; c < active_cols(); c++)
        if (!input_known[k * STORE_DIM + c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic issue_compute(input int r);
    if (row_ready(r))
      send_request(CMD_COMPUTE, ROW_W'(r), COL_W'($urandom), VAL_W'($urandom));
  endtask

  // occasional stray load anywhere in the stores, or an early compute
  task automatic interleave_noise();
    logic [CMD_W-1:0] cmd;
    case ($urandom_range(0, 19))
      0, 1: begin
        case ($urandom_range(0, 2))
          0: cmd = CMD_LOAD_WEIGHT;
          1: cmd = CMD_LOAD_INPUT;
          default: cmd = CMD_LOAD_BIAS;
        endcase
        send_request(cmd, ROW_W'($urandom), COL_W'($urandom), pick_value());
      end
      2: issue_compute($urandom_range(0, STORE_DIM - 1));
      default: ;
    endcase
  endtask

  // load what rows r_lo..r_hi read; with refresh some known elements get new values
  task automatic load_operands(input int r_lo, input int r_hi, input bit refresh);
    for (int r = r_lo; r <= r_hi; r++) begin
      if (!bias_known[r] || (refresh && $urandom_range(0, 2) == 0))
        send_request(CMD_LOAD_BIAS, ROW_W'(r), COL_W'($urandom), pick_value());
      for (int k = 0; k < inner_act; k++) begin
        if (!weight_known[r * STORE_DIM + k] || (refresh && $urandom_range(0, 2) == 0))
          send_request(CMD_LOAD_WEIGHT, ROW_W'(r), COL_W'(k), pick_value());
        interleave_noise();
      end
    end
    for (int k = 0; k < inner_act; k++) begin
      for (int c = 0; c < active_cols(); c++) begin
        if (!input_known[k * STORE_DIM + c] || (refresh && $urandom_range(0, 2) == 0))
          send_request(CMD_LOAD_INPUT, ROW_W'(k), COL_W'(c), pick_value());
        interleave_noise();
      end
    end
  endtask

  // saturation both ways, floor rounding, ignored fields, rows out of range
  task automatic test_directed_cases();
    set_dims(7'd4, 7'd2, 7'd3);
    // row 0: positive and negative clipping against the most negative bias
    send_request(CMD_LOAD_WEIGHT, 6'd0, 6'd0, 16'sh7FFF);
    send_request(CMD_LOAD_WEIGHT, 6'd0, 6'd1, 16'sh7FFF);
    send_request(CMD_LOAD_INPUT, 6'd0, 6'd0, 16'sh7FFF);
    send_request(CMD_LOAD_INPUT, 6'd1, 6'd0, 16'sh7FFF);
    send_request(CMD_LOAD_INPUT, 6'd0, 6'd1, 16'sh8000);
    send_request(CMD_LOAD_INPUT, 6'd1, 6'd1, 16'sh7FFF);
    send_request(CMD_LOAD_INPUT, 6'd0, 6'd2, 16'sh8000);
    send_request(CMD_LOAD_INPUT, 6'd1, 6'd2, 16'sh8000);
    send_request(CMD_LOAD_BIAS, 6'd0, 6'd63, 16'sh8000);
    send_request(CMD_COMPUTE, 6'd0, 6'd63, 16'shFFFF);
    // row 2: small negative sum floors away from zero
    send_request(CMD_LOAD_WEIGHT, 6'd2, 6'd0, 16'shFFFF);
    send_request(CMD_LOAD_WEIGHT, 6'd2, 6'd1, 16'sh0000);
    send_request(CMD_LOAD_BIAS, 6'd2, 6'd0, 16'sh0000);
    send_request(CMD_COMPUTE, 6'd2, 6'd0, 16'sh0000);
    send_request(CMD_LOAD_WEIGHT, 6'd2, 6'd1, 16'sh0100);
    send_request(CMD_COMPUTE, 6'd2, 6'd21, 16'sh7FFF);
    // loads beyond the used sizes are still stored
    send_request(CMD_LOAD_WEIGHT, 6'd63, 6'd63, 16'sh5A5A);
    send_request(CMD_LOAD_INPUT, 6'd63, 6'd63, 16'shA5A5);
    send_request(CMD_LOAD_BIAS, 6'd63, 6'd42, 16'sh7FFF);
    // rows at and past rows_used give nothing
    send_request(CMD_COMPUTE, 6'd4, 6'd0, 16'sh0000);
    send_request(CMD_COMPUTE, 6'd63, 6'd63, 16'sh0000);
  endtask

  // register extremes: 127 and 0 clamp, full inner dimension, full 64-element rows
  task automatic test_shape_extremes();
    set_dims(7'd127, 7'd64, 7'd0);
    load_operands(63, 63, 1'b1);
    issue_compute(63);
    send_request(CMD_LOAD_WEIGHT, 6'd63, COL_W'($urandom), pick_value());
    issue_compute(63);
    issue_compute(0);
    set_dims(7'd1, 7'd0, 7'd64);
    load_operands(0, 0, 1'b1);
    issue_compute(0);
    issue_compute(1);
    send_request(CMD_LOAD_INPUT, 6'd0, 6'd63, pick_value());
    issue_compute(0);
  endtask

  // random small layers: fill operands, then computes mixed with reloads and strays
  task automatic test_random_layers();
    int goal;
    int r;
    int k;
    goal = requests_done + 140;
    calm_after = goal - 30;
    while (requests_done < goal) begin
      set_dims(DIM_W'($urandom_range(1, 6)), DIM_W'($urandom_range(1, 6)),
               DIM_W'($urandom_range(1, 10)));
      gaps_on = ($urandom_range(0, 3) != 0);
      load_operands(0, rows_act - 1, 1'b1);
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 3) == 0) issue_compute($urandom_range(0, STORE_DIM - 1));
        else issue_compute($urandom_range(0, rows_act - 1));
        repeat ($urandom_range(0, 2)) begin
          r = $urandom_range(0, rows_act - 1);
          k = $urandom_range(0, inner_act - 1);
          case ($urandom_range(0, 2))
            0: send_request(CMD_LOAD_WEIGHT, ROW_W'(r), COL_W'(k), pick_value());
            1: send_request(CMD_LOAD_INPUT, ROW_W'(k),
                            COL_W'($urandom_range(0, active_cols() - 1)), pick_value());
            default: send_request(CMD_LOAD_BIAS, ROW_W'(r), COL_W'($urandom), pick_value());
          endcase
        end
        interleave_noise();
      end
    end
  endtask

  // compare each output element with the oldest prediction
  always @(posedge clk) begin : check_results
    layer_element_t want;
    if (!rst && out_valid) begin
      if (expected_elements.size() == 0) begin
        report_mismatch($sformatf("unexpected element row %0d col %0d value %0d",
                                  out_row, out_col, out_value));
      end else begin
        want = expected_elements.pop_front();
        if (out_row !== want.row)
          report_mismatch($sformatf("out_row %0d, want %0d", out_row, want.row));
        if (out_col !== want.col)
          report_mismatch($sformatf("row %0d out_col %0d, want %0d", want.row, out_col,
                                    want.col));
        if (out_value !== want.value)
          report_mismatch($sformatf("row %0d col %0d out_value %0d, want %0d", want.row,
                                    want.col, out_value, want.value));
        if (saturated !== want.sat)
          report_mismatch($sformatf("row %0d col %0d saturated %b, want %b", want.row,
                                    want.col, saturated, want.sat));
        if (last !== want.last)
          report_mismatch($sformatf("row %0d col %0d last %b, want %b", want.row,
                                    want.col, last, want.last));
      end
    end
  end

  // watchdog on cycles with no request, result or register write
  always @(posedge clk) begin
    if (rst || (start && !busy) || out_valid || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_shape_extremes();
    test_random_layers();
    wait_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
